// ===== rtl/tcc_pkg.sv =====
// text console cursor engine: shared package
// field widths, request and control codes, sequencer control struct
// no dependencies
`default_nettype none

package tcc_pkg;

  localparam int REQ_TYPE_W  = 2;
  localparam int CHAR_W      = 8;
  localparam int READ_COL_W  = 7;
  localparam int READ_ROW_W  = 5;
  localparam int CUR_COL_W   = 7;
  localparam int CUR_ROW_W   = 5;
  localparam int CUR_LIN_W   = 11;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = ATTR_W + CHAR_W;

  localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic write;
    logic scroll;
  } tcc_put_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tcc_if.sv =====
// text console cursor engine: request and response channel interfaces
// valid/ready handshake with payload; depends on tcc_pkg
`default_nettype none

interface tcc_req_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [CHAR_W-1:0]     char_code;
  logic [READ_COL_W-1:0] read_col;
  logic [READ_ROW_W-1:0] read_row;

  modport source (output valid, req_type, char_code, read_col, read_row, input ready);
  modport sink   (input valid, req_type, char_code, read_col, read_row, output ready);
endinterface

interface tcc_rsp_if import tcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CUR_COL_W-1:0] cur_col;
  logic [CUR_ROW_W-1:0] cur_row;
  logic [CUR_LIN_W-1:0] cur_linear;
  logic [CHAR_W-1:0]    cell_char;
  logic [ATTR_W-1:0]    cell_attr;

  modport source (output valid, cur_col, cur_row, cur_linear, cell_char, cell_attr,
                  input ready);
  modport sink   (input valid, cur_col, cur_row, cur_linear, cell_char, cell_attr,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tcc_ram.sv =====
// text console cursor engine: generic simple dual-port ram
// one write port, one read port with registered read data; no dependencies
`default_nettype none

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcc_cursor.sv =====
// text console cursor engine: cursor update for one put-character word
// control codes, column wrap and row overflow; depends on tcc_pkg
`default_nettype none

module tcc_cursor import tcc_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int CW      = $clog2(COLUMNS),
  parameter int RW      = $clog2(ROWS)
) (
  input  wire logic [CW-1:0]     col,
  input  wire logic [RW-1:0]     row,
  input  wire logic [CHAR_W-1:0] ch,
  output logic      [CW-1:0]     col_next,
  output logic      [RW-1:0]     row_next,
  output tcc_put_ctl_t           ctl
);

  logic [CW:0] c;
  logic [RW:0] r;
  logic [CW:0] tab_sum;

  always_comb begin
    c         = {1'b0, col};
    r         = {1'b0, row};
    tab_sum   = {1'b0, col} + (CW+1)'(8);
    ctl.write = 1'b0;
    case (ch)
      CH_NL: begin
        c = '0;
        r = {1'b0, row} + (RW+1)'(1);
      end
      CH_CR: begin
        c = '0;
      end
      CH_TAB: begin
        c = {tab_sum[CW:3], 3'b000};
      end
      CH_BS: begin
        if (col == '0) begin
          c = (CW+1)'(COLUMNS - 1);
          if (row != '0) begin
            r = {1'b0, row} - (RW+1)'(1);
          end
        end else begin
          c = {1'b0, col} - (CW+1)'(1);
        end
      end
      default: begin
        ctl.write = 1'b1;
        c = {1'b0, col} + (CW+1)'(1);
      end
    endcase
    if (c >= (CW+1)'(COLUMNS)) begin
      c = '0;
      r = r + (RW+1)'(1);
    end
    ctl.scroll = 1'b0;
    if (r >= (RW+1)'(ROWS)) begin
      ctl.scroll = 1'b1;
      r = (RW+1)'(ROWS - 1);
    end
    col_next = c[CW-1:0];
    row_next = r[RW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_cursor_engine_unit.sv =====
// text console cursor engine: top level with sequencer, screen ram and cursor
// depends on tcc_pkg, tcc_if, tcc_ram, tcc_cursor
//
// channel   dir  handshake     word
// req       in   valid/ready   req_type, char_code, read_col, read_row
// rsp       out  valid/ready   cur_col, cur_row, cur_linear, cell_char, cell_attr
// cfg       in   cfg_wr_en     cfg_wr_data -> text_attr
//
// put (ordinary character or control code): S_PUT; unused type: S_RESP; read: S_READ then S_RESP
// a scroll adds an S_COPY pass that moves rows 1..ROWS-1 up one row, then an S_FILL pass that blanks the bottom row
// clear: an S_FILL pass over every cell, one write per cell through the single screen ram write port
// after reset a zeroing sweep over every cell runs before req is ready
// req is ready only when the sequencer is idle; rsp is a single output register
`default_nettype none

module text_console_cursor_engine_unit import tcc_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  tcc_req_if.sink                req,
  tcc_rsp_if.source              rsp,
  input  wire logic              cfg_wr_en,
  input  wire logic [ATTR_W-1:0] cfg_wr_data
);

  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int COPY_N = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_COPY,
    S_FILL,
    S_READ,
    S_RESP
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         pos_col, pos_col_next;
  logic [RW-1:0]         pos_row, pos_row_next;
  logic [AW-1:0]         cnt, cnt_next;
  logic [AW-1:0]         cur_lin;
  logic [ATTR_W-1:0]     text_attr;
  logic                  fill_zero;
  logic                  sweep_done;
  logic                  rsp_valid;
  logic                  load_out;
  logic                  out_free;
  logic                  accept;
  logic                  finish;

  logic [REQ_TYPE_W-1:0] req_kind;
  logic [CHAR_W-1:0]     req_char;
  logic [READ_COL_W-1:0] req_col;
  logic [READ_ROW_W-1:0] req_row;

  logic [CW-1:0]         put_col;
  logic [RW-1:0]         put_row;
  tcc_put_ctl_t          put_ctl;

  logic [CW-1:0]         rd_col;
  logic [RW-1:0]         rd_row;
  logic [CW-1:0]         op_col;
  logic [RW-1:0]         op_row;
  logic [AW-1:0]         lin;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CELL_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [CELL_W-1:0]     ram_rdata;

  tcc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  tcc_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_cursor (
    .col     (pos_col),
    .row     (pos_row),
    .ch      (req_char),
    .col_next(put_col),
    .row_next(put_row),
    .ctl     (put_ctl)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;

  // clamped read coordinates
  always_comb begin
    rd_col = CW'(req_col);
    rd_row = RW'(req_row);
    if (int'(req_col) > COLUMNS - 1) begin
      rd_col = CW'(COLUMNS - 1);
    end
    if (int'(req_row) > ROWS - 1) begin
      rd_row = RW'(ROWS - 1);
    end
  end

  // shared linear address unit
  assign op_col = (state == S_READ) ? rd_col : pos_col_next;
  assign op_row = (state == S_READ) ? rd_row : pos_row_next;
  assign lin    = AW'(op_row) * AW'(COLUMNS) + AW'(op_col);

  always_comb begin
    state_next   = state;
    pos_col_next = pos_col;
    pos_row_next = pos_row;
    cnt_next     = cnt;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    finish       = 1'b0;
    load_out     = 1'b0;
    sweep_done   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_PUT: begin
              state_next = S_PUT;
            end
            REQ_CLEAR: begin
              state_next   = S_FILL;
              cnt_next     = '0;
              pos_col_next = '0;
              pos_row_next = '0;
            end
            REQ_READ: begin
              state_next = S_READ;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_PUT: begin
        pos_col_next = put_col;
        pos_row_next = put_row;
        if (put_ctl.write) begin
          ram_we    = 1'b1;
          ram_waddr = cur_lin;
          ram_wdata = {text_attr, req_char};
        end
        if (put_ctl.scroll) begin
          cnt_next   = '0;
          state_next = S_COPY;
        end else begin
          finish = 1'b1;
        end
      end
      S_COPY: begin
        // read one row down, write the word read in the previous cycle
        if (cnt != AW'(COPY_N)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt + AW'(COLUMNS);
          cnt_next  = cnt + AW'(1);
        end else begin
          state_next = S_FILL;
        end
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt - AW'(1);
          ram_wdata = ram_rdata;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = fill_zero ? '0 : {text_attr, BLANK_CHAR};
        if (cnt == AW'(CELLS - 1)) begin
          if (fill_zero) begin
            sweep_done = 1'b1;
            state_next = S_IDLE;
          end else begin
            finish = 1'b1;
          end
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        ram_raddr  = lin;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      if (out_free) begin
        load_out   = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_zero <= 1'b1;
      cnt       <= '0;
      pos_col   <= '0;
      pos_row   <= '0;
      cur_lin   <= '0;
      rsp_valid <= 1'b0;
      text_attr <= ATTR_RESET;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      pos_col <= pos_col_next;
      pos_row <= pos_row_next;
      if (sweep_done) begin
        fill_zero <= 1'b0;
      end
      if (cfg_wr_en) begin
        text_attr <= cfg_wr_data;
      end
      if (state == S_PUT) begin
        cur_lin <= lin;
      end else if (accept && req.req_type == REQ_CLEAR) begin
        cur_lin <= '0;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      req_kind <= req.req_type;
      req_char <= req.char_code;
      req_col  <= req.read_col;
      req_row  <= req.read_row;
    end
    if (load_out) begin
      rsp.cur_col    <= CUR_COL_W'(pos_col_next);
      rsp.cur_row    <= CUR_ROW_W'(pos_row_next);
      rsp.cur_linear <= CUR_LIN_W'(lin);
      if (req_kind == REQ_READ) begin
        rsp.cell_char <= ram_rdata[CHAR_W-1:0];
        rsp.cell_attr <= ram_rdata[CELL_W-1:CHAR_W];
      end else begin
        rsp.cell_char <= '0;
        rsp.cell_attr <= '0;
      end
    end
  end

  // a pending response word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("response word overwritten");

  // cursor stays on the screen whenever a word can be taken
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((int'(pos_col) < COLUMNS) && (int'(pos_row) < ROWS)))
    else $error("cursor off screen");

  // the zeroing sweep runs once after reset and never again
  a_sweep_once: assert property (@(posedge clk) disable iff (rst)
    !fill_zero |=> !fill_zero)
    else $error("zeroing sweep restarted");

  // linear cursor register tracks the cursor while idle
  a_lin_track: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !fill_zero) |->
      (cur_lin == AW'(pos_row) * AW'(COLUMNS) + AW'(pos_col)))
    else $error("linear cursor out of step");

endmodule

`default_nettype wire
